[rtl/hrst_pkg.sv]
`timescale 1ns / 1ps

package hrst_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int LEVEL_W     = 10;
    localparam int PIX_W       = 11;
    localparam int TIME_W      = 32;
    localparam int SLICE_W     = 10;
    localparam int INDEX_W     = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;

    // input tdata: time_us, hall_sample
    localparam int IN_FIELDS_W = TIME_W + SAMPLE_BITS;
    localparam int IN_W        = ((IN_FIELDS_W + 7) / 8) * 8;
    // output tdata: slice_index, revolutions
    localparam int OUT_FIELDS_W = SLICE_W + TIME_W;
    localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

    // product width of elapsed time by slice count
    localparam int NUM_W = TIME_W + PIX_W;
    localparam int CNT_W = $clog2(NUM_W);

    localparam int DIFF_W = ((SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W) + 1;

    localparam logic [LEVEL_W-1:0] NEUTRAL_RESET = LEVEL_W'(518);
    localparam logic [LEVEL_W-1:0] MARGIN_RESET  = LEVEL_W'(50);
    localparam logic [PIX_W-1:0]   PIXELS_RESET  = PIX_W'(64);
    localparam logic [PIX_W-1:0]   PIXELS_MAX    = PIX_W'(1024);
    localparam logic [TIME_W-1:0]  PERIOD_RESET  = TIME_W'(100000000);
    localparam logic [INDEX_W-1:0] INDEX_MAX     = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEUTRAL = 2'd0,
        REG_MARGIN  = 2'd1,
        REG_PIXELS  = 2'd2,
        REG_SPARE   = 2'd3
    } cfg_reg_t;

    // clamp the slice count into 1..1024
    function automatic logic [PIX_W-1:0] eff_pixels(input logic [PIX_W-1:0] pix);
        logic [PIX_W-1:0] res;
        if (pix == '0) begin
            res = PIX_W'(1);
        end else if (pix > PIXELS_MAX) begin
            res = PIXELS_MAX;
        end else begin
            res = pix;
        end
        return res;
    endfunction

endpackage

[rtl/hall_revolution_slice_tracker_core.sv]
`timescale 1ns / 1ps

// Hall revolution slice tracker.
//
// Input stream (s_*): one transfer per sensor tick, carrying the microsecond
// timestamp and the raw Hall converter sample. A tick with a rising magnet
// detection latches the revolution period, restarts the revolution timer and
// bumps the revolution count. The tick then yields the angular slice index
// floor(elapsed * angular_pixels / period), saturated at 65535.
// Output stream (m_*): one transfer each time the slice index changes; tuser
// flags the dark slice (index at or beyond angular_pixels).
// Config port (cfg_*): always ready; write only while the block is idle.
//
// Flow: an accepted tick is multiplied (32x11) in ST_MUL, then divided in the
// restoring divider in ST_DIV (one quotient bit per cycle over the 43-bit
// product), and the result is registered out of ST_DONE.
// s_tready returns together with the result, so the block takes no new tick
// until the last one is through. A tick with a zero period skips the divider.
// A finished tick with a new index holds in its last state while the output
// register is full; reset restores the control state and configuration.
module hall_revolution_slice_tracker_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // config write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hrst_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hrst_pkg::CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata fields from bit 0: time_us[31:0], hall_sample[SAMPLE_BITS-1:0], zero pad
    input  logic [hrst_pkg::IN_W-1:0]      s_tdata,
    // output stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata fields from bit 0: slice_index[9:0], revolutions[31:0], zero pad
    output logic [hrst_pkg::OUT_W-1:0]     m_tdata,
    // m_tuser fields from bit 0: show_blank
    output logic                           m_tuser
);
    import hrst_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                state_reg, state_next;

    logic [LEVEL_W-1:0]    neutral_reg, neutral_next;
    logic [LEVEL_W-1:0]    margin_reg, margin_next;
    logic [PIX_W-1:0]      pixels_reg, pixels_next;

    logic                  seen_reg, seen_next;
    logic [TIME_W-1:0]     start_reg, start_next;
    logic [TIME_W-1:0]     period_reg, period_next;
    logic [TIME_W-1:0]     count_reg, count_next;
    logic [INDEX_W-1:0]    slice_reg, slice_next;
    logic                  blank_shown_reg, blank_shown_next;

    logic [TIME_W-1:0]     elapsed_reg, elapsed_next;
    logic [NUM_W-1:0]      num_reg, num_next;
    logic [TIME_W-1:0]     rem_reg, rem_next;
    logic [INDEX_W-1:0]    quo_reg, quo_next;
    logic                  ovf_reg, ovf_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;

    logic                  m_valid_reg, m_valid_next;
    logic [SLICE_W-1:0]    m_slice_reg, m_slice_next;
    logic                  m_blank_reg, m_blank_next;
    logic [TIME_W-1:0]     m_rev_reg, m_rev_next;

    // input field split
    logic [TIME_W-1:0]      in_time;
    logic [SAMPLE_BITS-1:0] in_sample;
    assign in_time   = s_tdata[TIME_W-1:0];
    assign in_sample = s_tdata[TIME_W +: SAMPLE_BITS];

    // magnet detection on the incoming sample
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        diff_abs;
    logic                     det;
    assign diff = $signed({{(DIFF_W-SAMPLE_BITS){1'b0}}, in_sample})
                - $signed({{(DIFF_W-LEVEL_W){1'b0}}, neutral_reg});
    assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign det = diff_abs > {{(DIFF_W-LEVEL_W){1'b0}}, margin_reg};

    logic [PIX_W-1:0] pix_eff;
    assign pix_eff = eff_pixels(pixels_reg);

    // one restoring division step: shift in the next product bit
    logic [TIME_W:0] div_shift;
    logic            div_ge;
    assign div_shift = {rem_reg, num_reg[NUM_W-1]};
    assign div_ge    = div_shift >= {1'b0, period_reg};

    logic [INDEX_W-1:0] idx;
    assign idx = ovf_reg ? INDEX_MAX : quo_reg;

    logic in_xfer, out_free;
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next       = state_reg;
        neutral_next     = neutral_reg;
        margin_next      = margin_reg;
        pixels_next      = pixels_reg;
        seen_next        = seen_reg;
        start_next       = start_reg;
        period_next      = period_reg;
        count_next       = count_reg;
        slice_next       = slice_reg;
        blank_shown_next = blank_shown_reg;
        elapsed_next     = elapsed_reg;
        num_next         = num_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        ovf_next         = ovf_reg;
        cnt_next         = cnt_reg;
        m_valid_next     = m_valid_reg;
        m_slice_next     = m_slice_reg;
        m_blank_next     = m_blank_reg;
        m_rev_next       = m_rev_reg;

        // retire the pending result
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_NEUTRAL: neutral_next = cfg_data[LEVEL_W-1:0];
                REG_MARGIN:  margin_next  = cfg_data[LEVEL_W-1:0];
                REG_PIXELS:  pixels_next  = cfg_data[PIX_W-1:0];
                default:     ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    seen_next = det;
                    if (det && !seen_reg) begin
                        // rising detection: latch period, restart the turn
                        period_next  = in_time - start_reg;
                        start_next   = in_time;
                        count_next   = count_reg + TIME_W'(1);
                        elapsed_next = '0;
                    end else begin
                        elapsed_next = in_time - start_reg;
                    end
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                num_next = NUM_W'(elapsed_reg) * NUM_W'(pix_eff);
                rem_next = '0;
                quo_next = '0;
                cnt_next = '0;
                ovf_next = (period_reg == '0);
                state_next = (period_reg == '0) ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
                // the remainder stays below the period, so it fits the time width
                rem_next = TIME_W'(div_ge ? (div_shift - {1'b0, period_reg}) : div_shift);
                num_next = {num_reg[NUM_W-2:0], 1'b0};
                quo_next = {quo_reg[INDEX_W-2:0], div_ge};
                // any quotient bit above the index width saturates
                ovf_next = ovf_reg | quo_reg[INDEX_W-1];
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (idx == slice_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    slice_next   = idx;
                    m_valid_next = 1'b1;
                    m_rev_next   = count_reg;
                    if (idx < {{(INDEX_W-PIX_W){1'b0}}, pix_eff}) begin
                        blank_shown_next = 1'b0;
                        m_slice_next     = idx[SLICE_W-1:0];
                        m_blank_next     = 1'b0;
                    end else begin
                        blank_shown_next = 1'b1;
                        m_slice_next     = '0;
                        m_blank_next     = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            neutral_reg     <= NEUTRAL_RESET;
            margin_reg      <= MARGIN_RESET;
            pixels_reg      <= PIXELS_RESET;
            seen_reg        <= 1'b0;
            start_reg       <= '0;
            period_reg      <= PERIOD_RESET;
            count_reg       <= '0;
            slice_reg       <= '0;
            blank_shown_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
            ovf_reg         <= 1'b0;
            cnt_reg         <= '0;
        end else begin
            state_reg       <= state_next;
            neutral_reg     <= neutral_next;
            margin_reg      <= margin_next;
            pixels_reg      <= pixels_next;
            seen_reg        <= seen_next;
            start_reg       <= start_next;
            period_reg      <= period_next;
            count_reg       <= count_next;
            slice_reg       <= slice_next;
            blank_shown_reg <= blank_shown_next;
            m_valid_reg     <= m_valid_next;
            ovf_reg         <= ovf_next;
            cnt_reg         <= cnt_next;
        end
        // datapath, no reset needed
        elapsed_reg <= elapsed_next;
        num_reg     <= num_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        m_slice_reg <= m_slice_next;
        m_blank_reg <= m_blank_next;
        m_rev_reg   <= m_rev_next;
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tuser   = m_blank_reg;
    assign m_tdata   = {{(OUT_W-OUT_FIELDS_W){1'b0}}, m_rev_reg, m_slice_reg};

    // the blank flag on a pending transfer matches the tracked blank state
    a_blank_track: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_blank_reg == blank_shown_reg))
        else $error("pending blank flag disagrees with tracked blank state");

    // a shown slice lies inside the configured slice count
    a_slice_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_blank_reg) |->
            ({1'b0, m_slice_reg} < pix_eff))
        else $error("shown slice outside slice count");

    // an accepted tick keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> !s_tready)
        else $error("input ready right after accept");

endmodule

[tb/sv/tb_hall_revolution_slice_tracker_core.sv]
`timescale 1ns / 1ps

module tb_hall_revolution_slice_tracker_core;
    import hrst_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 7;
    // give a no-result tick room to finish inside the block
    localparam int SETTLE_CYCLES = 100;
    // long receiver hold-off used to back the block up into its input
    localparam int HOLD_CYCLES   = 1500;
    // longest legal quiet stretch is the hold-off plus one tick; allow many times that
    localparam int STALL_LIMIT   = 20000;
    localparam int DIR_ROWS      = 25;
    localparam int PHASES        = 8;

    typedef struct packed {
        logic [SLICE_W-1:0] slice;
        logic               blank;
        logic [TIME_W-1:0]  revs;
    } slice_result_t;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_NO_RESULT,
        ROW_RESULT
    } row_kind_t;

    typedef struct packed {
        logic [TIME_W-1:0]      t;
        logic [SAMPLE_BITS-1:0] smp;
        row_kind_t              kind;
        logic [SLICE_W-1:0]     e_slice;
        logic                   e_blank;
        logic [TIME_W-1:0]      e_revs;
    } tick_row_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] neutral;
        logic [CFG_DATA_W-1:0] margin;
        logic [CFG_DATA_W-1:0] pixels;
        logic                  rand_cfg;
        logic [6:0]            idle_pct;
        logic [6:0]            stall_pct;
        logic [15:0]           items;
    } phase_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // fields from bit 0: time_us[31:0], hall_sample[9:0], zero pad
    logic [IN_W-1:0]       s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // fields from bit 0: slice_index[9:0], revolutions[31:0], zero pad
    logic [OUT_W-1:0]      m_tdata;
    // fields from bit 0: show_blank
    logic                  m_tuser;

    hall_revolution_slice_tracker_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // Directed ticks, default configuration right after reset. Typed rows are
    // the ones readable at a glance; the rest go through the slice predictor.
    tick_row_t dir_rows [DIR_ROWS] = '{
        // quiet sensor, index still 0: nothing shown
        '{32'd0,          10'd518,  ROW_NO_RESULT, 10'd0,  1'b0, 32'd0},
        '{32'd1562499,    10'd518,  ROW_NO_RESULT, 10'd0,  1'b0, 32'd0},
        // first slice boundary of the reset period
        '{32'd1562500,    10'd518,  ROW_RESULT,    10'd1,  1'b0, 32'd0},
        // end of the reset period: dark slice
        '{32'd100000000,  10'd518,  ROW_RESULT,    10'd0,  1'b1, 32'd0},
        // largest timestamp: index moves on, dark slice shown again
        '{32'hFFFF_FFFF,  10'd518,  ROW_RESULT,    10'd0,  1'b1, 32'd0},
        '{32'hFFFF_FFFF,  10'd518,  ROW_NO_RESULT, 10'd0,  1'b0, 32'd0},
        // full-scale sample: first revolution, timer restarts
        '{32'd200000000,  10'd1023, ROW_RESULT,    10'd0,  1'b0, 32'd1},
        // zero sample while the magnet is still seen: no new revolution
        '{32'd200000001,  10'd0,    ROW_NO_RESULT, 10'd0,  1'b0, 32'd0},
        // threshold edges above and below neutral
        '{32'd250000000,  10'd568,  ROW_PREDICT,   10'd0,  1'b0, 32'd0},
        '{32'd250000000,  10'd569,  ROW_PREDICT,   10'd0,  1'b0, 32'd0},
        '{32'd250000000,  10'd467,  ROW_PREDICT,   10'd0,  1'b0, 32'd0},
        '{32'd250000000,  10'd468,  ROW_PREDICT,   10'd0,  1'b0, 32'd0},
        // second rising detection at the same timestamp: zero period saturates
        '{32'd250000000,  10'd0,    ROW_RESULT,    10'd0,  1'b1, 32'd3},
        '{32'd250000001,  10'd518,  ROW_NO_RESULT, 10'd0,  1'b0, 32'd0},
        // one-microsecond periods, then a quotient past the 16-bit ceiling
        '{32'd250000001,  10'd1023, ROW_PREDICT,   10'd0,  1'b0, 32'd0},
        '{32'd250000001,  10'd518,  ROW_PREDICT,   10'd0,  1'b0, 32'd0},
        '{32'd250000002,  10'd1023, ROW_PREDICT,   10'd0,  1'b0, 32'd0},
        '{32'd250001026,  10'd1023, ROW_PREDICT,   10'd0,  1'b0, 32'd0},
        '{32'd250100000,  10'd518,  ROW_PREDICT,   10'd0,  1'b0, 32'd0},
        // revolution across the timestamp wrap
        '{32'hFFFF_FF00,  10'd1023, ROW_PREDICT,   10'd0,  1'b0, 32'd0},
        '{32'hFFFF_FF80,  10'd518,  ROW_PREDICT,   10'd0,  1'b0, 32'd0},
        '{32'h0000_0100,  10'd0,    ROW_PREDICT,   10'd0,  1'b0, 32'd0},
        '{32'h0000_0200,  10'd518,  ROW_PREDICT,   10'd0,  1'b0, 32'd0},
        '{32'h0000_02FF,  10'd518,  ROW_PREDICT,   10'd0,  1'b0, 32'd0},
        '{32'h0000_0300,  10'd518,  ROW_PREDICT,   10'd0,  1'b0, 32'd0}
    };

    // Random phases: raw register writes (bit 10 set on neutral and margin in
    // two of them, to show the upper bit is dropped), idle and stall rates.
    phase_t phases [PHASES] = '{
        '{11'd518,  11'd50,   11'd64,   1'b0, 7'd0,  7'd0,  16'd250},
        '{11'd0,    11'd0,    11'd1,    1'b0, 7'd64, 7'd0,  16'd200},
        '{11'd1023, 11'd1023, 11'd1024, 1'b0, 7'd0,  7'd64, 16'd250},
        '{11'd512,  11'd100,  11'd0,    1'b0, 7'd6,  7'd6,  16'd200},
        '{11'd300,  11'd1044, 11'd2047, 1'b0, 7'd64, 7'd64, 16'd250},
        '{11'd1624, 11'd200,  11'd16,   1'b0, 7'd0,  7'd0,  16'd200},
        '{11'd0,    11'd0,    11'd0,    1'b1, 7'd6,  7'd6,  16'd300},
        '{11'd518,  11'd50,   11'd64,   1'b0, 7'd64, 7'd64, 16'd300}
    };

    // slice predictor: configuration copy and tracker state
    logic [LEVEL_W-1:0] cfg_neutral  = NEUTRAL_RESET;
    logic [LEVEL_W-1:0] cfg_margin   = MARGIN_RESET;
    logic [PIX_W-1:0]   cfg_pixels   = PIXELS_RESET;
    logic               mag_latched  = 1'b0;
    logic [TIME_W-1:0]  rev_start    = '0;
    logic [TIME_W-1:0]  rev_period   = PERIOD_RESET;
    logic [INDEX_W-1:0] shown_index  = '0;
    logic               dark_shown   = 1'b0;
    logic [TIME_W-1:0]  rev_count    = '0;

    slice_result_t pending_slices [$];

    int errors       = 0;
    int quiet_cycles = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int rx_hold      = 0;

    // revolution generator state
    logic [TIME_W-1:0] gen_time  = '0;
    int                gen_step  = 1;
    int                gen_ticks = 1;
    int                gen_tick  = 0;

    function automatic logic [PIX_W-1:0] slices_per_turn(input logic [PIX_W-1:0] raw);
        logic [PIX_W-1:0] n;
        n = raw;
        if (raw == 0) begin
            n = PIX_W'(1);
        end else if (raw > 1024) begin
            n = PIXELS_MAX;
        end
        return n;
    endfunction

    // Advance the tracker by one tick and report the slice it would show.
    task automatic track_tick(input logic [TIME_W-1:0] now, input logic [SAMPLE_BITS-1:0] smp,
                              output bit has_res, output slice_result_t res);
        int                 diff;
        int                 magn;
        bit                 det;
        logic [TIME_W-1:0]  elapsed;
        logic [63:0]        quo;
        logic [INDEX_W-1:0] idx;
        logic [PIX_W-1:0]   pix;
        pix  = slices_per_turn(cfg_pixels);
        diff = int'(smp) - int'(cfg_neutral);
        magn = (diff < 0) ? -diff : diff;
        det  = magn > int'(cfg_margin);
        if (det && !mag_latched) begin
            rev_period = now - rev_start;
            rev_start  = now;
            rev_count  = rev_count + 1;
        end
        mag_latched = det;
        elapsed = now - rev_start;
        if (rev_period == 0) begin
            idx = '1;
        end else begin
            quo = (64'(elapsed) * 64'(pix)) / 64'(rev_period);
            idx = (quo > 64'hFFFF) ? 16'hFFFF : quo[INDEX_W-1:0];
        end
        has_res = idx != shown_index;
        res     = '0;
        if (has_res) begin
            shown_index = idx;
            if (idx < pix) begin
                dark_shown = 1'b0;
                res.slice  = idx[SLICE_W-1:0];
            end else begin
                dark_shown = 1'b1;
                res.blank  = 1'b1;
            end
            res.revs = rev_count;
        end
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_NEUTRAL: cfg_neutral = value[LEVEL_W-1:0];
            REG_MARGIN:  cfg_margin  = value[LEVEL_W-1:0];
            REG_PIXELS:  cfg_pixels  = value;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Offer one tick, hold it until the transfer, then queue its slice.
    task automatic send_tick(input logic [TIME_W-1:0] now, input logic [SAMPLE_BITS-1:0] smp,
                             input row_kind_t kind, input slice_result_t typed);
        bit            has_res;
        slice_result_t res;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = IN_W'({smp, now});
        do @(posedge aclk); while (!s_tready);
        track_tick(now, smp, has_res, res);
        case (kind)
            ROW_RESULT:    pending_slices.push_back(typed);
            ROW_NO_RESULT: ;
            default: begin
                if (has_res) pending_slices.push_back(res);
            end
        endcase
    endtask

    // Drop valid for a random stretch so gaps land on every stage of a tick.
    task automatic tick_gap();
        int gap;
        if ($urandom_range(99) < tx_idle_pct) begin
            gap = $urandom_range(96, 1);
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // Pause the sender until every queued slice has been seen, then let any
    // tick that shows nothing run out inside the block.
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_slices.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] quiet_sample();
        int off;
        int v;
        off = $urandom_range(int'(cfg_margin));
        v   = $urandom_range(1) ? int'(cfg_neutral) + off : int'(cfg_neutral) - off;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return SAMPLE_BITS'(v);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pulse_sample();
        int lo_top;
        int hi_bot;
        lo_top = int'(cfg_neutral) - int'(cfg_margin) - 1;
        hi_bot = int'(cfg_neutral) + int'(cfg_margin) + 1;
        if (lo_top >= 0 && (hi_bot > 1023 || $urandom_range(1) == 1)) begin
            return SAMPLE_BITS'($urandom_range(lo_top, 0));
        end else if (hi_bot <= 1023) begin
            return SAMPLE_BITS'($urandom_range(1023, hi_bot));
        end
        // no sample can clear the margin: anything goes
        return SAMPLE_BITS'($urandom_range(1023));
    endfunction

    // Mostly well-formed revolutions (magnet pulse, then evenly spaced quiet
    // ticks with jitter), the rest random noise that breaks the sequence.
    task automatic next_tick(output logic [TIME_W-1:0] now, output logic [SAMPLE_BITS-1:0] smp);
        int period;
        int jitter;
        if ($urandom_range(99) < 15) begin
            now = $urandom;
            smp = SAMPLE_BITS'($urandom_range(1023));
            if ($urandom_range(1) == 1) gen_time = now;
        end else begin
            if (gen_tick == 0) begin
                gen_ticks = $urandom_range(24, 3);
                period    = ($urandom_range(19) == 0) ? $urandom_range(2000000, 20000)
                                                      : $urandom_range(20000, gen_ticks);
                gen_step  = period / gen_ticks;
                // start some revolutions just short of the timestamp wrap
                if ($urandom_range(15) == 0) gen_time = 32'hFFFF_FFFF - $urandom_range(100000);
            end
            now = gen_time;
            if ((gen_tick == 0 && $urandom_range(19) != 0) ||
                (gen_tick == 1 && $urandom_range(2) == 0)) begin
                smp = pulse_sample();
            end else begin
                smp = quiet_sample();
            end
            jitter   = $urandom_range(gen_step / 4);
            gen_time = ($urandom_range(1) == 1) ? gen_time + gen_step + jitter
                                                : gen_time + gen_step - jitter;
            gen_tick = (gen_tick + 1 == gen_ticks) ? 0 : gen_tick + 1;
        end
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested.
    always @(negedge aclk) begin
        if (rx_hold != 0) begin
            m_tready = 1'b0;
            rx_hold  = rx_hold - 1;
        end else begin
            m_tready = ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Compare every result transfer with the oldest queued slice.
    always @(posedge aclk) begin : check_slices
        slice_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_slices.size() == 0) begin
                $display("%0t: unexpected result slice_index %0d show_blank %0d revolutions %0d",
                         $time, m_tdata[SLICE_W-1:0], m_tuser, m_tdata[SLICE_W +: TIME_W]);
                errors = errors + 1;
            end else begin
                want = pending_slices.pop_front();
                if (m_tdata[SLICE_W-1:0] !== want.slice) begin
                    $display("%0t: slice_index expected %0d actual %0d",
                             $time, want.slice, m_tdata[SLICE_W-1:0]);
                    errors = errors + 1;
                end
                if (m_tuser !== want.blank) begin
                    $display("%0t: show_blank expected %0d actual %0d",
                             $time, want.blank, m_tuser);
                    errors = errors + 1;
                end
                if (m_tdata[SLICE_W +: TIME_W] !== want.revs) begin
                    $display("%0t: revolutions expected %0d actual %0d",
                             $time, want.revs, m_tdata[SLICE_W +: TIME_W]);
                    errors = errors + 1;
                end
            end
        end
    end

    // Watchdog: count cycles with no transfer on any channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int                     row;
        int                     ph;
        int                     n;
        logic [TIME_W-1:0]      now;
        logic [SAMPLE_BITS-1:0] smp;
        slice_result_t          typed;
        logic [CFG_DATA_W-1:0]  nv;
        logic [CFG_DATA_W-1:0]  mv;
        logic [CFG_DATA_W-1:0]  pv;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed ticks on the reset configuration, no idling
        for (row = 0; row < DIR_ROWS; row++) begin
            typed = '{dir_rows[row].e_slice, dir_rows[row].e_blank, dir_rows[row].e_revs};
            send_tick(dir_rows[row].t, dir_rows[row].smp, dir_rows[row].kind, typed);
        end
        drain();

        for (ph = 0; ph < PHASES; ph++) begin
            nv = phases[ph].neutral;
            mv = phases[ph].margin;
            pv = phases[ph].pixels;
            if (phases[ph].rand_cfg) begin
                nv = CFG_DATA_W'($urandom_range(2047));
                mv = CFG_DATA_W'($urandom_range(300));
                pv = CFG_DATA_W'($urandom_range(2047, 1));
            end
            // reconfigure only with the block idle
            write_reg(REG_NEUTRAL, nv);
            write_reg(REG_MARGIN, mv);
            write_reg(REG_PIXELS, pv);
            // the spare index must leave everything as it was
            if (ph == 3) write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(2047)));
            tx_idle_pct  = phases[ph].idle_pct;
            rx_stall_pct = phases[ph].stall_pct;
            gen_tick     = 0;
            for (n = 0; n < int'(phases[ph].items); n++) begin
                next_tick(now, smp);
                send_tick(now, smp, ROW_PREDICT, '0);
                // back the block up: hold the receiver while ticks keep coming
                if (ph == 5 && n == 40) rx_hold = HOLD_CYCLES;
                tick_gap();
            end
            drain();
        end

        if (pending_slices.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_slices.size());
            errors = errors + pending_slices.size();
        end
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
